// File: hdl/segment_intersection_test_defines.svh
// Assertion macros for the segment intersection test block.
// Used by the files that check behavior; no other dependencies.
`ifndef SEGMENT_INTERSECTION_TEST_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_DEFINES_SVH
`ifndef SYNTHESIS
`define SIT_ASSERT_ALWAYS(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sit: check failed");
`define SIT_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sit: check failed");
`else
`define SIT_ASSERT_ALWAYS(name, cond)
`define SIT_ASSERT_NEXT(name, pre, post)
`endif
`endif

// File: hdl/sit_pkg.sv
// Shared widths, word types and helpers for the segment intersection test.
// No dependencies.
package sit_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int NSUM_W     = DIFF_W + CROSS_W + 1;
    localparam int QUO_W      = COORD_BITS + FRAC_BITS;
    localparam int POINT_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int NTEST      = 4;

    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t STAT_DISJOINT = 2'd0;
    localparam status_t STAT_TOUCH    = 2'd1;
    localparam status_t STAT_CROSS    = 2'd2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [CROSS_W-1:0]    cross_t;
    typedef logic signed [NSUM_W-1:0]     nsum_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_start_x;
        logic signed [COORD_BITS-1:0] first_start_y;
        logic signed [COORD_BITS-1:0] first_end_x;
        logic signed [COORD_BITS-1:0] first_end_y;
        logic signed [COORD_BITS-1:0] second_start_x;
        logic signed [COORD_BITS-1:0] second_start_y;
        logic signed [COORD_BITS-1:0] second_end_x;
        logic signed [COORD_BITS-1:0] second_end_y;
    } pair_t;

    typedef struct packed {
        status_t                   status;
        logic signed [POINT_W-1:0] point_x;
        logic signed [POINT_W-1:0] point_y;
    } result_t;

    typedef struct packed {
        diff_t x;
        diff_t y;
    } vec_t;

    typedef struct packed {
        logic   touch;
        logic   crossing;
        cross_t den;
        cross_t num;
        diff_t  vx;
        diff_t  vy;
        coord_t px;
        coord_t py;
    } geom_t;

    typedef struct packed {
        logic               neg;
        logic [CROSS_W-1:0] rem;
        logic [QUO_W-1:0]   dlow;
        logic [CROSS_W-1:0] dvs;
    } lane_t;

    typedef struct packed {
        status_t status;
        lane_t   x;
        lane_t   y;
    } point_t;

    // strictly opposite signs, both nonzero
    function automatic logic opposite(cross_t a, cross_t b);
        logic a_neg;
        logic b_neg;
        a_neg = a[CROSS_W-1];
        b_neg = b[CROSS_W-1];
        return (a_neg && !b_neg && b != '0) || (b_neg && !a_neg && a != '0);
    endfunction

endpackage

// File: hdl/segment_intersection_test.sv
// Segment intersection test: one segment pair in, one classification out per word.
// Depends on sit_pkg, sit_geom, sit_point, sit_div and the assertion macro header.
//
// Usage:
//   Input channel pair_valid / pair_stall / pair carries one pair of segments with
//   signed integer endpoints. Output channel result_valid / result_stall / result
//   carries status (disjoint, touching, crossing) and the crossing point in
//   signed Q16.16, zero unless the pair crosses properly.
//   A word is taken at a rising edge with valid high and stall low.
// Pipeline: an accepted word passes through three geometry stages, three operand
//   stages, one stage per quotient bit of the two 32-stage restoring divider
//   lanes, and the output register.
// Throughput: one word per cycle while no stall holds the pipeline; every stage,
//   the divider lanes included, is a plain register stage.
// Reset: all valid bits clear; no word is in flight and result_valid is low.
// Stall: while result_valid is high and result_stall is high the whole pipeline
//   holds, and pair_stall goes high in the same cycle; nothing is dropped or
//   repeated. Bubbles in flight are not squeezed out.
module segment_intersection_test (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pair_valid,
    output logic              pair_stall,
    input  sit_pkg::pair_t    pair,
    output logic              result_valid,
    input  logic              result_stall,
    output sit_pkg::result_t  result
);
    import sit_pkg::*;
    `include "segment_intersection_test_defines.svh"

    localparam int PIPE = 6 + QUO_W;   // stages ahead of the output register

    logic             adv;
    logic [PIPE-1:0]  vld_reg;
    logic [PIPE-1:0]  vld_next;
    status_t          stat_reg [QUO_W];
    geom_t            geom;
    point_t           point;
    logic [QUO_W-1:0] quo_x, quo_y;
    logic             neg_x, neg_y;
    result_t          res_next, res_reg;
    logic             res_vld_reg;
    logic             point_ok;

    // advance everything unless a finished word is held by the receiver
    assign adv        = !(res_vld_reg && result_stall);
    assign pair_stall = !adv;

    sit_geom u_geom (
        .clk   (clk),
        .adv   (adv),
        .pair  (pair),
        .geom  (geom)
    );

    sit_point u_point (
        .clk   (clk),
        .adv   (adv),
        .geom  (geom),
        .point (point)
    );

    sit_div u_div_x (
        .clk   (clk),
        .adv   (adv),
        .lane  (point.x),
        .quo   (quo_x),
        .neg   (neg_x)
    );

    sit_div u_div_y (
        .clk   (clk),
        .adv   (adv),
        .lane  (point.y),
        .quo   (quo_y),
        .neg   (neg_y)
    );

    // valid bits ride alongside the data
    assign vld_next = {vld_reg[PIPE-2:0], pair_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            res_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= vld_next;
            res_vld_reg <= vld_reg[PIPE-1];
        end
    end

    // status travels next to the divider lanes
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stat_reg[0] <= point.status;
            for (int i = 1; i < QUO_W; i++)
            begin
                stat_reg[i] <= stat_reg[i-1];
            end
            res_reg <= res_next;
        end
    end

    // apply sign, drop the point unless the segments cross properly
    always_comb
    begin
        res_next.status  = stat_reg[QUO_W-1];
        res_next.point_x = '0;
        res_next.point_y = '0;
        if (stat_reg[QUO_W-1] == STAT_CROSS)
        begin
            res_next.point_x = neg_x ? -POINT_W'(quo_x) : POINT_W'(quo_x);
            res_next.point_y = neg_y ? -POINT_W'(quo_y) : POINT_W'(quo_y);
        end
    end

    assign result_valid = res_vld_reg;
    assign result       = res_reg;

    assign point_ok = res_reg.status == STAT_CROSS
                      || (res_reg.point_x == '0 && res_reg.point_y == '0);

    `SIT_ASSERT_ALWAYS(a_point_only_on_cross, !res_vld_reg || point_ok)
    `SIT_ASSERT_NEXT(a_hold_while_stalled, !adv, $stable(vld_reg) && $stable(res_vld_reg))
    `SIT_ASSERT_NEXT(a_word_enters, pair_valid && !pair_stall, vld_reg[0])

endmodule

// File: hdl/sit_geom.sv
// Front stages: differences, products, cross/dot products and classification flags.
// Depends on sit_pkg.
module sit_geom (
    input  logic          clk,
    input  logic          adv,
    input  sit_pkg::pair_t pair,
    output sit_pkg::geom_t geom
);
    import sit_pkg::*;

    // stage 1: differences
    vec_t   da_next [NTEST];
    vec_t   db_next [NTEST];
    vec_t   da_reg  [NTEST];
    vec_t   db_reg  [NTEST];
    vec_t   v_next, w_next, v1_reg, w1_reg;
    coord_t px1_reg, py1_reg;

    // stage 2: products
    prod_t  pab_reg [NTEST];
    prod_t  pba_reg [NTEST];
    prod_t  pxx_reg [NTEST];
    prod_t  pyy_reg [NTEST];
    prod_t  sl_reg  [NTEST];
    prod_t  sr_reg  [NTEST];
    prod_t  dl_reg, dr_reg;
    vec_t   v2_reg;
    coord_t px2_reg, py2_reg;

    // stage 3
    geom_t  geom_next, geom_reg;

    always_comb
    begin
        // endpoint tests: first start, first end on segment two; then the reverse
        da_next[0].x = $signed(pair.second_start_x) - $signed(pair.first_start_x);
        da_next[0].y = $signed(pair.second_start_y) - $signed(pair.first_start_y);
        db_next[0].x = $signed(pair.second_end_x)   - $signed(pair.first_start_x);
        db_next[0].y = $signed(pair.second_end_y)   - $signed(pair.first_start_y);
        da_next[1].x = $signed(pair.second_start_x) - $signed(pair.first_end_x);
        da_next[1].y = $signed(pair.second_start_y) - $signed(pair.first_end_y);
        db_next[1].x = $signed(pair.second_end_x)   - $signed(pair.first_end_x);
        db_next[1].y = $signed(pair.second_end_y)   - $signed(pair.first_end_y);
        da_next[2].x = $signed(pair.first_start_x)  - $signed(pair.second_start_x);
        da_next[2].y = $signed(pair.first_start_y)  - $signed(pair.second_start_y);
        db_next[2].x = $signed(pair.first_end_x)    - $signed(pair.second_start_x);
        db_next[2].y = $signed(pair.first_end_y)    - $signed(pair.second_start_y);
        da_next[3].x = $signed(pair.first_start_x)  - $signed(pair.second_end_x);
        da_next[3].y = $signed(pair.first_start_y)  - $signed(pair.second_end_y);
        db_next[3].x = $signed(pair.first_end_x)    - $signed(pair.second_end_x);
        db_next[3].y = $signed(pair.first_end_y)    - $signed(pair.second_end_y);
        v_next.x = $signed(pair.first_end_x)  - $signed(pair.first_start_x);
        v_next.y = $signed(pair.first_end_y)  - $signed(pair.first_start_y);
        w_next.x = $signed(pair.second_end_x) - $signed(pair.second_start_x);
        w_next.y = $signed(pair.second_end_y) - $signed(pair.second_start_y);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int t = 0; t < NTEST; t++)
            begin
                da_reg[t] <= da_next[t];
                db_reg[t] <= db_next[t];
            end
            v1_reg  <= v_next;
            w1_reg  <= w_next;
            px1_reg <= pair.first_start_x;
            py1_reg <= pair.first_start_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int t = 0; t < NTEST; t++)
            begin
                pab_reg[t] <= $signed(da_reg[t].x) * $signed(db_reg[t].y);
                pba_reg[t] <= $signed(da_reg[t].y) * $signed(db_reg[t].x);
                pxx_reg[t] <= $signed(da_reg[t].x) * $signed(db_reg[t].x);
                pyy_reg[t] <= $signed(da_reg[t].y) * $signed(db_reg[t].y);
            end
            // side of each endpoint against the other segment's line
            sl_reg[0] <= $signed(v1_reg.x) * $signed(da_reg[0].y);
            sr_reg[0] <= $signed(v1_reg.y) * $signed(da_reg[0].x);
            sl_reg[1] <= $signed(v1_reg.x) * $signed(db_reg[0].y);
            sr_reg[1] <= $signed(v1_reg.y) * $signed(db_reg[0].x);
            sl_reg[2] <= $signed(w1_reg.x) * $signed(da_reg[2].y);
            sr_reg[2] <= $signed(w1_reg.y) * $signed(da_reg[2].x);
            sl_reg[3] <= $signed(w1_reg.x) * $signed(db_reg[2].y);
            sr_reg[3] <= $signed(w1_reg.y) * $signed(db_reg[2].x);
            dl_reg    <= $signed(v1_reg.x) * $signed(w1_reg.y);
            dr_reg    <= $signed(v1_reg.y) * $signed(w1_reg.x);
            v2_reg    <= v1_reg;
            px2_reg   <= px1_reg;
            py2_reg   <= py1_reg;
        end
    end

    always_comb
    begin
        cross_t cr;
        cross_t dt;
        cross_t side [NTEST];
        geom_next.touch = 1'b0;
        for (int t = 0; t < NTEST; t++)
        begin
            cr = $signed(pab_reg[t]) - $signed(pba_reg[t]);
            dt = $signed(pxx_reg[t]) + $signed(pyy_reg[t]);
            if (cr == '0 && (dt[CROSS_W-1] || dt == '0))
            begin
                geom_next.touch = 1'b1;
            end
            side[t] = $signed(sl_reg[t]) - $signed(sr_reg[t]);
        end
        geom_next.den      = $signed(dl_reg) - $signed(dr_reg);
        geom_next.num      = side[2];
        geom_next.crossing = opposite(side[0], side[1]) && opposite(side[2], side[3])
                             && geom_next.den != '0;
        geom_next.vx       = v2_reg.x;
        geom_next.vy       = v2_reg.y;
        geom_next.px       = px2_reg;
        geom_next.py       = py2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            geom_reg <= geom_next;
        end
    end

    assign geom = geom_reg;

endmodule

// File: hdl/sit_point.sv
// Middle stages: status code, crossing numerators and divider operands.
// Depends on sit_pkg.
module sit_point (
    input  logic           clk,
    input  logic           adv,
    input  sit_pkg::geom_t  geom,
    output sit_pkg::point_t point
);
    import sit_pkg::*;

    status_t st4_reg, st5_reg;
    nsum_t   mxa_reg, mxb_reg, mya_reg, myb_reg;
    nsum_t   nx_reg, ny_reg;
    cross_t  den4_reg, den5_reg;
    status_t st4_next;
    point_t  point_next, point_reg;

    // magnitude split into the divider's starting remainder and low dividend bits
    function automatic lane_t mk_lane(nsum_t n, cross_t d);
        logic [NSUM_W-1:0]           mag;
        logic [NSUM_W+FRAC_BITS-1:0] dsh;
        lane_t                       l;
        mag    = n[NSUM_W-1] ? NSUM_W'(-n) : NSUM_W'(n);
        dsh    = (NSUM_W + FRAC_BITS)'(mag) << FRAC_BITS;
        l.neg  = n[NSUM_W-1] ^ d[CROSS_W-1];
        l.rem  = mag[COORD_BITS +: CROSS_W];
        l.dlow = dsh[QUO_W-1:0];
        l.dvs  = d[CROSS_W-1] ? CROSS_W'(-d) : CROSS_W'(d);
        return l;
    endfunction

    always_comb
    begin
        case ({geom.touch, geom.crossing})
            2'b10, 2'b11: st4_next = STAT_TOUCH;
            2'b01:        st4_next = STAT_CROSS;
            default:      st4_next = STAT_DISJOINT;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st4_reg  <= st4_next;
            mxa_reg  <= $signed(geom.px) * $signed(geom.den);
            mxb_reg  <= $signed(geom.vx) * $signed(geom.num);
            mya_reg  <= $signed(geom.py) * $signed(geom.den);
            myb_reg  <= $signed(geom.vy) * $signed(geom.num);
            den4_reg <= geom.den;

            st5_reg  <= st4_reg;
            nx_reg   <= $signed(mxa_reg) + $signed(mxb_reg);
            ny_reg   <= $signed(mya_reg) + $signed(myb_reg);
            den5_reg <= den4_reg;

            point_reg <= point_next;
        end
    end

    always_comb
    begin
        point_next.status = st5_reg;
        point_next.x      = mk_lane(nx_reg, den5_reg);
        point_next.y      = mk_lane(ny_reg, den5_reg);
    end

    assign point = point_reg;

endmodule

// File: hdl/sit_div.sv
// Pipelined restoring divider lane: one quotient bit per stage.
// Depends on sit_pkg.
module sit_div (
    input  logic                        clk,
    input  logic                        adv,
    input  sit_pkg::lane_t              lane,
    output logic [sit_pkg::QUO_W-1:0]   quo,
    output logic                        neg
);
    import sit_pkg::*;

    logic [CROSS_W-1:0] rem_reg  [QUO_W];
    logic [QUO_W-1:0]   dlow_reg [QUO_W];
    logic [QUO_W-1:0]   q_reg    [QUO_W];
    logic [CROSS_W-1:0] dvs_reg  [QUO_W];
    logic               neg_reg  [QUO_W];

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_stage
        logic [CROSS_W-1:0] rem_in;
        logic [QUO_W-1:0]   dlow_in;
        logic [QUO_W-1:0]   q_in;
        logic [CROSS_W-1:0] dvs_in;
        logic               neg_in;
        logic [CROSS_W:0]   trial;
        logic [CROSS_W:0]   diff;
        logic               ge;

        if (i == 0)
        begin : g_first
            assign rem_in  = lane.rem;
            assign dlow_in = lane.dlow;
            assign q_in    = '0;
            assign dvs_in  = lane.dvs;
            assign neg_in  = lane.neg;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[i-1];
            assign dlow_in = dlow_reg[i-1];
            assign q_in    = q_reg[i-1];
            assign dvs_in  = dvs_reg[i-1];
            assign neg_in  = neg_reg[i-1];
        end

        assign trial = {rem_in, dlow_in[QUO_W-1]};
        assign diff  = trial - {1'b0, dvs_in};
        assign ge    = trial >= {1'b0, dvs_in};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i]  <= ge ? diff[CROSS_W-1:0] : trial[CROSS_W-1:0];
                dlow_reg[i] <= dlow_in << 1;
                q_reg[i]    <= {q_in[QUO_W-2:0], ge};
                dvs_reg[i]  <= dvs_in;
                neg_reg[i]  <= neg_in;
            end
        end
    end

    assign quo = q_reg[QUO_W-1];
    assign neg = neg_reg[QUO_W-1];

endmodule
